>>> rtl/sas_pkg.sv
// Shared codes and constants of the sprite animation sequencer.
`default_nettype none
package sas_pkg;

    // Item function codes.
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_SELECT = 2'd2;

    // Animation modes.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_CYCLE  = 2'd2;
    localparam logic [1:0] MODE_SEQ    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ANIM_MODE   = 2'd0;
    localparam logic [1:0] CFG_ONE_SHOT    = 2'd1;
    localparam logic [1:0] CFG_ANIM_SPEED  = 2'd2;
    localparam logic [1:0] CFG_FRAME_COUNT = 2'd3;

    // Field widths fixed by the interface.
    localparam int CFG_DATA_W  = 8;
    localparam int FRAME_OUT_W = 6;
    localparam int FC_W        = 7;

    // Total number of frames; the wrap limit taken from the frame count register is capped at it.
    localparam int FRAME_TOTAL = 64;

    // Reset value of the frame count register.
    localparam logic [FC_W-1:0] FRAME_COUNT_RST = 7'd64;

    typedef logic [1:0] code_t;

endpackage
`default_nettype wire

>>> rtl/sas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/sprite_animation_sequencer_top.sv
// Top level of the sprite animation sequencer: control, state and both tables.
//
// Channel   Direction  Ports                                             Handshake
// input     in         func, seq_number, entry_position, frame_value,    start / busy
//                      last_entry
// result    out        current_frame, anim_done                          result_strobe
// config    in         cfg_index, cfg_data                               cfg_we
//
// For every word, the accepting edge issues the table reads and writes, the next
// cycle takes the registered read data, and the cycle after that shows the
// result under result_strobe while a new word may be accepted. The registered
// read of the tables is why the response state lies between acceptance and result.
// Reset is asynchronous and active low; all sequence lengths read as one after
// reset through per-sequence valid bits, so no clearing pass is needed.
// The receiver cannot stall; busy holds start off while a word is in flight.
`default_nettype none
module sprite_animation_sequencer_top
    import sas_pkg::*;
#(
    parameter int NUM_SEQS   = 16,
    parameter int SEQ_LEN    = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            func,
    input  wire logic [3:0]            seq_number,
    input  wire logic [3:0]            entry_position,
    input  wire logic [5:0]            frame_value,
    input  wire logic                  last_entry,
    output logic                       result_strobe,
    output logic [FRAME_OUT_W-1:0]     current_frame,
    output logic                       anim_done,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SEQ_W   = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
    localparam int POS_W   = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
    localparam int LEN_W   = $clog2(SEQ_LEN + 1);
    localparam int DEPTH   = NUM_SEQS * SEQ_LEN;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FRM_W   = (FRAME_TOTAL > 64) ? 7 : 6;

    // Sequencer states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    // Configuration registers.
    logic [1:0]      anim_mode_reg;
    logic            one_shot_reg;
    logic [7:0]      anim_speed_reg;
    logic [FC_W-1:0] frame_count_reg;

    // Animation state.
    logic             state_reg, state_next;
    logic             strobe_reg;
    logic [7:0]       tick_count_reg, tick_count_next;
    logic [FRM_W-1:0] frame_reg, frame_next;
    logic [POS_W-1:0] seq_position_reg, seq_position_next;
    logic [SEQ_W-1:0] active_seq_reg, active_seq_next;
    logic             done_reg, done_next;
    logic [LEN_W-1:0] len_cache_reg, len_cache_next;
    logic [NUM_SEQS-1:0] len_valid_reg, len_valid_next;
    logic             pend_frame_reg, pend_frame_next;
    logic             pend_len_reg, pend_len_next;

    // Table ports.
    logic              store_we, store_re;
    logic [ADDR_W-1:0] store_waddr, store_raddr;
    logic [5:0]        store_rdata;
    logic              len_we, len_re;
    logic [SEQ_W-1:0]  len_waddr, len_raddr;
    logic [LEN_W-1:0]  len_wdata, len_rdata;

    // Intermediate values.
    logic             in_accept;
    logic             seq_ok, pos_ok;
    logic [8:0]       tick_inc;
    logic             step_due;
    logic [FC_W-1:0]  frame_limit;
    logic [7:0]       frame_inc;
    logic [LEN_W-1:0] pos_inc;
    logic [POS_W-1:0] pos_new;

    assign in_accept     = start && (state_reg == ST_IDLE);
    assign busy          = (state_reg == ST_RESP);
    assign result_strobe = strobe_reg;
    assign current_frame = frame_reg[FRAME_OUT_W-1:0];
    assign anim_done     = done_reg;

    assign seq_ok = int'(seq_number) < NUM_SEQS;
    assign pos_ok = int'(entry_position) < SEQ_LEN;

    // Prescaler: a step is due when the incremented count reaches the speed.
    assign tick_inc = 9'(tick_count_reg) + 9'd1;
    assign step_due = tick_inc >= {1'b0, anim_speed_reg};

    // Wrap limit for cycling through all frames, capped at the frame total.
    assign frame_limit = (int'(frame_count_reg) > FRAME_TOTAL) ?
                         FC_W'(FRAME_TOTAL) : frame_count_reg;
    assign frame_inc   = 8'(frame_reg) + 8'd1;

    // Next position within the active sequence, with end handling.
    assign pos_inc = LEN_W'(seq_position_reg) + LEN_W'(1);
    always_comb
    begin
        if (pos_inc >= len_cache_reg)
        begin
            pos_new = one_shot_reg ? POS_W'(len_cache_reg - LEN_W'(1)) : '0;
        end
        else
        begin
            pos_new = POS_W'(pos_inc);
        end
    end

    // Item decode: state update and table accesses at acceptance, read data taken in response.
    always_comb
    begin
        state_next        = state_reg;
        tick_count_next   = tick_count_reg;
        frame_next        = frame_reg;
        seq_position_next = seq_position_reg;
        active_seq_next   = active_seq_reg;
        done_next         = done_reg;
        len_cache_next    = len_cache_reg;
        len_valid_next    = len_valid_reg;
        pend_frame_next   = 1'b0;
        pend_len_next     = 1'b0;
        store_we          = 1'b0;
        store_re          = 1'b0;
        store_waddr       = ADDR_W'(seq_number) * ADDR_W'(SEQ_LEN)
                            + ADDR_W'(entry_position);
        store_raddr       = ADDR_W'(active_seq_reg) * ADDR_W'(SEQ_LEN)
                            + ADDR_W'(pos_new);
        len_we            = 1'b0;
        len_re            = 1'b0;
        len_waddr         = SEQ_W'(seq_number);
        len_wdata         = LEN_W'(entry_position) + LEN_W'(1);
        len_raddr         = SEQ_W'(seq_number);

        if (state_reg == ST_RESP)
        begin
            state_next = ST_IDLE;
            if (pend_frame_reg)
            begin
                frame_next = FRM_W'(store_rdata);
            end
            if (pend_len_reg)
            begin
                len_cache_next = len_valid_reg[active_seq_reg] ? len_rdata : LEN_W'(1);
            end
        end
        else if (in_accept)
        begin
            state_next = ST_RESP;
            unique case (func)
                FUNC_TICK:
                begin
                    unique case (anim_mode_reg)
                        MODE_SINGLE:
                        begin
                            frame_next = '0;
                        end
                        MODE_CYCLE:
                        begin
                            tick_count_next = step_due ? 8'd0 : tick_inc[7:0];
                            if (step_due)
                            begin
                                frame_next = (frame_inc >= {1'b0, frame_limit}) ?
                                             '0 : FRM_W'(frame_inc);
                            end
                        end
                        MODE_SEQ:
                        begin
                            tick_count_next = step_due ? 8'd0 : tick_inc[7:0];
                            if (step_due)
                            begin
                                seq_position_next = pos_new;
                                store_re          = 1'b1;
                                pend_frame_next   = 1'b1;
                                if (pos_inc >= len_cache_reg && one_shot_reg)
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            tick_count_next = tick_count_reg;
                        end
                    endcase
                end
                FUNC_LOAD:
                begin
                    if (seq_ok && pos_ok)
                    begin
                        store_we = 1'b1;
                        if (last_entry)
                        begin
                            len_we = 1'b1;
                            len_valid_next[SEQ_W'(seq_number)] = 1'b1;
                            if (SEQ_W'(seq_number) == active_seq_reg)
                            begin
                                len_cache_next = len_wdata;
                            end
                        end
                    end
                end
                FUNC_SELECT:
                begin
                    if (seq_ok)
                    begin
                        active_seq_next   = SEQ_W'(seq_number);
                        seq_position_next = '0;
                        len_re            = 1'b1;
                        pend_len_next     = 1'b1;
                    end
                end
                default:
                begin
                    state_next = ST_RESP;
                end
            endcase
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anim_mode_reg   <= MODE_NONE;
            one_shot_reg    <= 1'b0;
            anim_speed_reg  <= 8'd0;
            frame_count_reg <= FRAME_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ANIM_MODE:   anim_mode_reg   <= cfg_data[1:0];
                CFG_ONE_SHOT:    one_shot_reg    <= cfg_data[0];
                CFG_ANIM_SPEED:  anim_speed_reg  <= cfg_data;
                CFG_FRAME_COUNT: frame_count_reg <= cfg_data[FC_W-1:0];
                default:         anim_speed_reg  <= anim_speed_reg;
            endcase
        end
    end

    // Control and animation state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            strobe_reg       <= 1'b0;
            tick_count_reg   <= '0;
            frame_reg        <= '0;
            seq_position_reg <= '0;
            active_seq_reg   <= '0;
            done_reg         <= 1'b0;
            len_cache_reg    <= LEN_W'(1);
            len_valid_reg    <= '0;
            pend_frame_reg   <= 1'b0;
            pend_len_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            strobe_reg       <= (state_reg == ST_RESP);
            tick_count_reg   <= tick_count_next;
            frame_reg        <= frame_next;
            seq_position_reg <= seq_position_next;
            active_seq_reg   <= active_seq_next;
            done_reg         <= done_next;
            len_cache_reg    <= len_cache_next;
            len_valid_reg    <= len_valid_next;
            pend_frame_reg   <= pend_frame_next;
            pend_len_reg     <= pend_len_next;
        end
    end

    // Frame entries of all sequences. Busy keeps a read from overlapping a
    // write of the same entry, so no forwarding is needed.
    sas_ram #(
        .WIDTH (6),
        .DEPTH (DEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (frame_value),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Sequence lengths; an entry without its valid bit reads as one.
    sas_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_SEQS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

`ifndef NO_ASSERTIONS
    // A word in flight is always followed by its result strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP) |=> strobe_reg)
        else $error("result strobe missing after response cycle");

    // An accepted word makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // The result strobe never coincides with busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> !busy)
        else $error("result strobe while busy");

    // The active sequence length is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        len_cache_reg != '0)
        else $error("active sequence length is zero");

    // Pending table reads exist only in the response cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_frame_reg || pend_len_reg) |-> (state_reg == ST_RESP))
        else $error("pending read outside response cycle");
`endif

endmodule
`default_nettype wire
